[src/pes_pkg.sv]
// ----------------------------------------------------------------------------
// pes_pkg - shared constants for the product-except-self block
// Data width and the default sequence capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_LEN_DEF = 64;

  typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

[src/pes_in_if.sv]
// ----------------------------------------------------------------------------
// pes_in_if - element input channel
// Valid/ready channel carrying one sequence element and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_in_if
  import pes_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

[src/pes_out_if.sv]
// ----------------------------------------------------------------------------
// pes_out_if - result output channel
// Valid/ready channel carrying one product with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_out_if
  import pes_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product;
  logic                     last_res;
  logic                     truncated;

  modport source (output valid, output product, output last_res, output truncated,
                  input ready);
  modport sink   (input valid, input product, input last_res, input truncated,
                  output ready);
endinterface

`default_nettype wire

[src/pes_ram.sv]
// ----------------------------------------------------------------------------
// pes_ram - single-port-write, single-port-read word memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_ram
  import pes_pkg::*;
#(
  parameter int DEPTH = MAX_LEN_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire word_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output      word_t         rdata_r
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/pes_mul.sv]
// ----------------------------------------------------------------------------
// pes_mul - shared wrapping multiplier
// Registered 32x32 multiply keeping the low word; holds when not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_mul
  import pes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire word_t a,
  input  wire word_t b,
  output      word_t p_r
);

  // low word of the product is the same for signed and unsigned operands
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

`default_nettype wire

[src/product_except_self.sv]
// ----------------------------------------------------------------------------
// product_except_self - product of all other elements, without division
// Collects a sequence, then streams one wrapped product per stored element.
// ----------------------------------------------------------------------------
// Elements arrive one per cycle on in_ch while the block is loading; the
// element flagged last closes the sequence. Up to MAX_LEN elements are
// stored; any beyond that are dropped and every result of that sequence
// carries truncated = 1. After the last element the block stops accepting
// input and runs two passes over the stored elements with one shared
// registered multiplier: a suffix pass (per element: memory read,
// multiply, accumulate) and a prefix-and-emit pass (per element: read,
// multiply for the result, multiply for the running prefix, accumulate).
// The prefix-and-emit pass holds while the result channel stalls. Results
// leave through an output register, so the last result may still be
// waiting while loading of the next sequence has already started.
// All products wrap modulo 2^32; a one-element sequence yields 1.
// ----------------------------------------------------------------------------
`default_nettype none

module product_except_self
  import pes_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pes_in_if.sink     in_ch,
  pes_out_if.source  out_ch
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SFX_RD,
    ST_SFX_MUL,
    ST_SFX_ACC,
    ST_PFX_RD,
    ST_PFX_MUL,
    ST_PFX_EMIT,
    ST_PFX_ACC
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;        // stored elements
  logic            ovf_r, ovf_nxt;        // element dropped this sequence
  logic [AW-1:0]   idx_r, idx_nxt;        // pass position
  logic [AW-1:0]   last_idx_r, last_idx_nxt;
  word_t           acc_r, acc_nxt;        // running suffix or prefix product

  logic            out_valid_r, out_valid_nxt;
  word_t           out_prod_r, out_prod_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_trunc_r, out_trunc_nxt;

  logic            val_we, sfx_we;
  word_t           val_rd, sfx_rd;
  logic            mul_en;
  word_t           mul_b, mul_p;

  logic            in_fire, full, out_free;

  assign in_ch.ready      = (state_r == ST_LOAD);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign full             = (cnt_r == CW'(MAX_LEN));
  assign out_free         = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.product   = out_prod_r;
  assign out_ch.last_res  = out_last_r;
  assign out_ch.truncated = out_trunc_r;

  // element store: written while loading, read by both passes
  pes_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_val_ram (
    .clk     (clk),
    .we      (val_we),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   (word_t'(in_ch.value)),
    .raddr   (idx_r),
    .rdata_r (val_rd)
  );

  // suffix products: written by the suffix pass, read by the emit pass
  pes_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_sfx_ram (
    .clk     (clk),
    .we      (sfx_we),
    .waddr   (idx_r),
    .wdata   (acc_r),
    .raddr   (idx_r),
    .rdata_r (sfx_rd)
  );

  pes_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (acc_r),
    .b   (mul_b),
    .p_r (mul_p)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    acc_nxt       = acc_r;
    out_prod_nxt  = out_prod_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    val_we        = 1'b0;
    sfx_we        = 1'b0;
    mul_en        = 1'b0;
    mul_b         = val_rd;

    // drop the held result once taken
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (!full) begin
            val_we  = 1'b1;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) begin
            // last position is count-1 after this item is stored or dropped
            last_idx_nxt = full ? AW'(cnt_r - 1'b1) : AW'(cnt_r);
            idx_nxt      = full ? AW'(cnt_r - 1'b1) : AW'(cnt_r);
            acc_nxt      = word_t'(1);
            state_nxt    = ST_SFX_RD;
          end
        end
      end

      ST_SFX_RD: begin
        // store suffix of everything right of idx, fetch value[idx]
        sfx_we    = 1'b1;
        state_nxt = ST_SFX_MUL;
      end

      ST_SFX_MUL: begin
        mul_en    = 1'b1;
        mul_b     = val_rd;
        state_nxt = ST_SFX_ACC;
      end

      ST_SFX_ACC: begin
        acc_nxt = mul_p;
        if (idx_r == '0) begin
          acc_nxt   = word_t'(1);
          state_nxt = ST_PFX_RD;
        end else begin
          idx_nxt   = AW'(idx_r - 1'b1);
          state_nxt = ST_SFX_RD;
        end
      end

      ST_PFX_RD: begin
        state_nxt = ST_PFX_MUL;
      end

      ST_PFX_MUL: begin
        // result = prefix * suffix
        mul_en    = 1'b1;
        mul_b     = sfx_rd;
        state_nxt = ST_PFX_EMIT;
      end

      ST_PFX_EMIT: begin
        // hold until the output register is free, then advance the prefix
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prod_nxt  = mul_p;
          out_last_nxt  = (idx_r == last_idx_r);
          out_trunc_nxt = ovf_r;
          mul_en        = 1'b1;
          mul_b         = val_rd;
          state_nxt     = ST_PFX_ACC;
        end
      end

      ST_PFX_ACC: begin
        acc_nxt = mul_p;
        if (idx_r == last_idx_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt   = AW'(idx_r + 1'b1);
          state_nxt = ST_PFX_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    last_idx_r  <= last_idx_nxt;
    acc_r       <= acc_nxt;
    out_prod_r  <= out_prod_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

endmodule

`default_nettype wire
